### rtl/core/lz4d_pkg.sv
// Shared constants, codes and types of the LZ4 block decompressor.
// No dependencies; every other file of the block but lz4d_ram imports this package.
package lz4d_pkg;

  // History window, a power of two between 1024 and 65536
  localparam int WINDOW_BYTES = 65536;
  localparam int HIST_AW      = $clog2(WINDOW_BYTES);
  localparam int LENGTH_BITS  = 24;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX   = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] CAP_RESET = LENGTH_BITS'(65536);

  localparam logic [1:0] OP_FEED  = 2'd0;
  localparam logic [1:0] OP_PULL  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [2:0] ST_WORKING  = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_OFFSET   = 3'd3;
  localparam logic [2:0] ST_CAPACITY = 3'd4;
  localparam logic [2:0] ST_REFUSED  = 3'd5;

  // Result of one item as decided by the sequence parser
  typedef struct packed {
    logic                   is_pull;
    logic                   out_valid;
    logic [7:0]             lit_byte;
    logic [2:0]             status;
    logic [LENGTH_BITS-1:0] copy_left;
    logic [LENGTH_BITS-1:0] out_length;
    logic [HIST_AW-1:0]     waddr;
    logic [HIST_AW-1:0]     raddr;
  } lz4d_res_t;

endpackage

### rtl/core/lz4d_in_if.sv
// Input channel of the LZ4 block decompressor: valid/ready plus one item.
// Depends on lz4d_pkg.
interface lz4d_in_if import lz4d_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] in_byte;
  logic       in_last;

  modport source(output valid, op, in_byte, in_last, input ready);
  modport sink(input valid, op, in_byte, in_last, output ready);
endinterface

### rtl/core/lz4d_out_if.sv
// Result channel of the LZ4 block decompressor: valid/ready plus one item.
// Depends on lz4d_pkg.
interface lz4d_out_if import lz4d_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   out_valid;
  logic [7:0]             out_byte;
  logic [2:0]             status;
  logic [LENGTH_BITS-1:0] copy_left;
  logic [LENGTH_BITS-1:0] out_length;

  modport source(output valid, out_valid, out_byte, status, copy_left, out_length,
                 input ready);
  modport sink(input valid, out_valid, out_byte, status, copy_left, out_length,
               output ready);
endinterface

### rtl/core/lz4_block_decompressor.sv
// Top level of the LZ4 block decompressor: parser, history RAM, byte stage
// with forwarding, output register. Depends on lz4d_pkg, lz4d_in_if,
// lz4d_out_if, lz4d_ram and lz4d_ctrl.
//
//  channel  direction  handshake     payload
//  in_s     in         valid/ready   op, in_byte, in_last
//  out_m    out        valid/ready   out_valid, out_byte, status, copy_left, out_length
//  cfg_*    in         cfg_we        cfg_data (out_capacity)
//
// One item per cycle unless the output stalls; one result per item, via the byte stage.
// The parser decides all of a result at accept; a pull reads the history RAM
// then, and its byte is written back as the item moves to the output register.
// A pull one byte behind the previous write takes the byte by forwarding.
// Reset is synchronous and needs no clearing pass; the history is unknown
// until written. A stalled output holds one result and one item in flight.
module lz4_block_decompressor import lz4d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [LENGTH_BITS-1:0] cfg_data,
  lz4d_in_if.sink                in_s,
  lz4d_out_if.source             out_m
);

  lz4d_res_t          res;
  lz4d_res_t          s1_res_r;
  logic               s1_valid_r, s1_valid_nxt;
  logic               s1_fwd_r;
  logic [7:0]         s1_fwd_data_r;
  logic               s1_adv;
  logic [7:0]         s1_byte;
  logic               acc;
  logic               ram_we;
  logic [7:0]         ram_rdata;

  logic                   o_valid_r, o_valid_nxt;
  logic                   o_outv_r;
  logic [7:0]             o_byte_r;
  logic [2:0]             o_status_r;
  logic [LENGTH_BITS-1:0] o_copy_r;
  logic [LENGTH_BITS-1:0] o_len_r;

  assign s1_adv     = s1_valid_r && (!o_valid_r || out_m.ready);
  assign in_s.ready = !s1_valid_r || s1_adv;
  assign acc        = in_s.valid && in_s.ready;

  lz4d_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .acc     (acc),
    .op      (in_s.op),
    .in_byte (in_s.in_byte),
    .in_last (in_s.in_last),
    .res     (res)
  );

  assign s1_byte = s1_res_r.is_pull ? (s1_fwd_r ? s1_fwd_data_r : ram_rdata)
                                    : s1_res_r.lit_byte;
  assign ram_we  = s1_adv && s1_res_r.out_valid;

  lz4d_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_BYTES)
  ) u_hist (
    .clk  (clk),
    .we   (ram_we),
    .waddr(s1_res_r.waddr),
    .wdata(s1_byte),
    .re   (acc && res.is_pull),
    .raddr(res.raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    o_valid_nxt = o_valid_r;
    if (s1_adv) begin
      o_valid_nxt = 1'b1;
    end else if (out_m.ready) begin
      o_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      o_valid_r  <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      o_valid_r  <= o_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_res_r      <= res;
      // the write landing this cycle is the one the read needs
      s1_fwd_r      <= ram_we && res.is_pull && (res.raddr == s1_res_r.waddr);
      s1_fwd_data_r <= s1_byte;
    end
    if (s1_adv) begin
      o_outv_r   <= s1_res_r.out_valid;
      o_byte_r   <= s1_res_r.out_valid ? s1_byte : 8'h00;
      o_status_r <= s1_res_r.status;
      o_copy_r   <= s1_res_r.copy_left;
      o_len_r    <= s1_res_r.out_length;
    end
  end

  assign out_m.valid      = o_valid_r;
  assign out_m.out_valid  = o_outv_r;
  assign out_m.out_byte   = o_byte_r;
  assign out_m.status     = o_status_r;
  assign out_m.copy_left  = o_copy_r;
  assign out_m.out_length = o_len_r;

`ifndef ASSERT_OFF
  // an accepted item always lands in the byte stage
  a_acc_s1: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> s1_valid_r)
    else $error("accepted item lost before byte stage");

  // forwarding only serves history reads
  a_fwd_pull: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_fwd_r) |-> s1_res_r.is_pull)
    else $error("forward flag on an item without a history read");

  // the byte stage moves on whenever the output register frees up
  a_s1_move: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !o_valid_r) |=> o_valid_r)
    else $error("byte stage did not advance into empty output register");
`endif

endmodule

### rtl/core/lz4d_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lz4d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold the last read word while no read is issued
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/lz4d_ctrl.sv
// Sequence parser of the LZ4 block decompressor: token, lengths, offsets,
// error checks and the block counters. Depends on lz4d_pkg.
module lz4d_ctrl import lz4d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [LENGTH_BITS-1:0] cfg_data,
  input  logic                   acc,
  input  logic [1:0]             op,
  input  logic [7:0]             in_byte,
  input  logic                   in_last,
  output lz4d_res_t              res
);

  typedef enum logic [8:0] {
    PH_TOKEN     = 9'b000000001,
    PH_LIT_EXT   = 9'b000000010,
    PH_LITERAL   = 9'b000000100,
    PH_OFF_LO    = 9'b000001000,
    PH_OFF_HI    = 9'b000010000,
    PH_MATCH_EXT = 9'b000100000,
    PH_COPY      = 9'b001000000,
    PH_DONE      = 9'b010000000,
    PH_FAILED    = 9'b100000000
  } phase_t;

  localparam logic [16:0] WIN_LIM = 17'(WINDOW_BYTES);

  phase_t                 phase_r, phase_nxt;
  logic [3:0]             mn_r, mn_nxt;
  logic [LENGTH_BITS-1:0] ll_r, ll_nxt;
  logic [LENGTH_BITS-1:0] ml_r, ml_nxt;
  logic [15:0]            dist_r, dist_nxt;
  logic [LENGTH_BITS-1:0] prod_r, prod_nxt;
  logic                   last_r, last_nxt;
  logic [LENGTH_BITS-1:0] cap_r;

  function automatic logic [LENGTH_BITS-1:0] sat3(input logic [LENGTH_BITS-1:0] a,
                                                  input logic [7:0] b,
                                                  input logic [2:0] c);
    logic [LENGTH_BITS+1:0] s;
    s = {2'b00, a} + (LENGTH_BITS+2)'(b) + (LENGTH_BITS+2)'(c);
    return (s > (LENGTH_BITS+2)'(LEN_MAX)) ? LEN_MAX : s[LENGTH_BITS-1:0];
  endfunction

  function automatic logic fits(input logic [LENGTH_BITS-1:0] len,
                                input logic [LENGTH_BITS-1:0] cap,
                                input logic [LENGTH_BITS-1:0] prod);
    logic [LENGTH_BITS-1:0] room;
    room = (cap > prod) ? cap - prod : '0;
    return len <= room;
  endfunction

  always_comb begin
    logic                   llk, mlk, fail;
    logic [2:0]             fail_code;
    logic [LENGTH_BITS-1:0] ll_v, ml_v, ll_dec, ml_dec;
    logic [15:0]            d;

    phase_nxt = phase_r;
    mn_nxt    = mn_r;
    ll_nxt    = ll_r;
    ml_nxt    = ml_r;
    dist_nxt  = dist_r;
    prod_nxt  = prod_r;
    last_nxt  = last_r;

    llk       = 1'b0;
    mlk       = 1'b0;
    fail      = 1'b0;
    fail_code = ST_TRUNC;
    ll_v      = ll_r;
    ml_v      = ml_r;
    ll_dec    = ll_r - LENGTH_BITS'(1);
    ml_dec    = ml_r - LENGTH_BITS'(1);
    d         = {in_byte, dist_r[7:0]};

    res            = '0;
    res.status     = ST_WORKING;
    res.waddr      = prod_r[HIST_AW-1:0];
    res.raddr      = prod_r[HIST_AW-1:0] - dist_r[HIST_AW-1:0];

    if (op == OP_START) begin
      phase_nxt = PH_TOKEN;
      mn_nxt    = '0;
      ll_nxt    = '0;
      ml_nxt    = '0;
      dist_nxt  = '0;
      prod_nxt  = '0;
      last_nxt  = 1'b0;
    end else if (op == OP_FEED && phase_r != PH_COPY) begin
      case (phase_r)
        PH_TOKEN: begin
          mn_nxt = in_byte[3:0];
          ll_v   = LENGTH_BITS'(in_byte[7:4]);
          ll_nxt = ll_v;
          if (in_byte[7:4] == 4'hF) begin
            if (in_last) begin
              fail = 1'b1;
            end else begin
              phase_nxt = PH_LIT_EXT;
            end
          end else begin
            llk = 1'b1;
          end
        end
        PH_LIT_EXT: begin
          ll_v   = sat3(ll_r, in_byte, 3'd0);
          ll_nxt = ll_v;
          if (in_byte == 8'hFF) begin
            fail = in_last;
          end else begin
            llk = 1'b1;
          end
        end
        PH_LITERAL: begin
          res.out_valid = 1'b1;
          res.lit_byte  = in_byte;
          prod_nxt      = prod_r + LENGTH_BITS'(1);
          ll_nxt        = ll_dec;
          if (ll_dec != '0) begin
            fail = in_last;
          end else if (in_last) begin
            phase_nxt  = PH_DONE;
            res.status = ST_OK;
          end else begin
            phase_nxt = PH_OFF_LO;
          end
        end
        PH_OFF_LO: begin
          dist_nxt = {8'h00, in_byte};
          if (in_last) begin
            fail = 1'b1;
          end else begin
            phase_nxt = PH_OFF_HI;
          end
        end
        PH_OFF_HI: begin
          dist_nxt = d;
          if (d == 16'd0 || LENGTH_BITS'(d) > prod_r || {1'b0, d} > WIN_LIM) begin
            fail      = 1'b1;
            fail_code = ST_OFFSET;
          end else if (mn_r == 4'hF) begin
            ml_nxt = LENGTH_BITS'(mn_r);
            if (in_last) begin
              fail = 1'b1;
            end else begin
              phase_nxt = PH_MATCH_EXT;
            end
          end else begin
            ml_v = LENGTH_BITS'(mn_r) + LENGTH_BITS'(4);
            mlk  = 1'b1;
          end
        end
        PH_MATCH_EXT: begin
          if (in_byte == 8'hFF) begin
            ml_nxt = sat3(ml_r, in_byte, 3'd0);
            fail   = in_last;
          end else begin
            ml_v = sat3(ml_r, in_byte, 3'd4);
            mlk  = 1'b1;
          end
        end
        default: begin
          res.status = ST_REFUSED;
        end
      endcase
    end else if (op == OP_PULL && phase_r == PH_COPY) begin
      res.is_pull   = 1'b1;
      res.out_valid = 1'b1;
      prod_nxt      = prod_r + LENGTH_BITS'(1);
      ml_nxt        = ml_dec;
      if (ml_dec == '0) begin
        if (last_r) begin
          phase_nxt  = PH_DONE;
          res.status = ST_OK;
        end else begin
          phase_nxt = PH_TOKEN;
        end
      end
    end else begin
      res.status = ST_REFUSED;
    end

    // literal length is final: route the sequence on
    if (llk) begin
      if (ll_v == '0) begin
        if (in_last) begin
          phase_nxt  = PH_DONE;
          res.status = ST_OK;
        end else begin
          phase_nxt = PH_OFF_LO;
        end
      end else if (in_last) begin
        fail = 1'b1;
      end else if (!fits(ll_v, cap_r, prod_r)) begin
        fail      = 1'b1;
        fail_code = ST_CAPACITY;
      end else begin
        phase_nxt = PH_LITERAL;
      end
    end

    // match length (with the 4 added) is final: queue the copy, or fail if it does not fit
    if (mlk) begin
      ml_nxt = ml_v;
      if (!fits(ml_v, cap_r, prod_r)) begin
        fail      = 1'b1;
        fail_code = ST_CAPACITY;
      end else begin
        last_nxt  = in_last;
        phase_nxt = PH_COPY;
      end
    end

    // drop queued lengths and stop the block
    if (fail) begin
      phase_nxt  = PH_FAILED;
      ll_nxt     = '0;
      ml_nxt     = '0;
      res.status = fail_code;
    end

    res.copy_left  = ml_nxt;
    res.out_length = prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TOKEN;
      mn_r    <= '0;
      ll_r    <= '0;
      ml_r    <= '0;
      dist_r  <= '0;
      prod_r  <= '0;
      last_r  <= 1'b0;
      cap_r   <= CAP_RESET;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
        mn_r    <= mn_nxt;
        ll_r    <= ll_nxt;
        ml_r    <= ml_nxt;
        dist_r  <= dist_nxt;
        prod_r  <= prod_nxt;
        last_r  <= last_nxt;
      end
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
    end
  end

`ifndef ASSERT_OFF
  // a match copy is only ever queued with a length
  a_copy_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_COPY |-> ml_r != '0)
    else $error("copy phase with no match bytes left");

  // literal run in progress always has bytes left
  a_lit_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_LITERAL |-> ll_r != '0)
    else $error("literal phase with empty run");

  // a failed block carries no queued lengths
  a_fail_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_FAILED |-> (ll_r == '0 && ml_r == '0))
    else $error("lengths left after failure");
`endif

endmodule
